// ----- rtl/dda_pkg.sv -----
// shared types and constants for the dda line rasterizer
// used by dda_div, dda_acc and dda_line_rasterizer; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dda_pkg;

  // fixed field width of each coordinate on the stream ports
  localparam int FIELD_W     = 6;
  localparam int IN_TDATA_W  = 24;  // four coordinates, already whole bytes
  localparam int OUT_TDATA_W = 16;  // two coordinates plus zero fill

  // sequencer states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_EMIT = 3'b100
  } dda_state_t;

  // accumulator controls from the sequencer
  typedef struct packed {
    logic load;  // load start point
    logic step;  // add increments
  } acc_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/dda_line_rasterizer.sv -----
// Line rasterizer (DDA). One input transfer describes a line; the block emits
// 1 + max(|dx|,|dy|) pixel transfers, the start pixel first, tlast on the final
// one. A line is accepted, then the shared bit-serial divider forms the
// minor-axis increment (skipped when the endpoints are equal), then the block
// emits one pixel per cycle while out_tready stays high. in_tready is low for
// the whole line; the last pixel sits in the output register while the next
// line is taken. Uses dda_pkg, dda_div and dda_acc.
`timescale 1ns / 1ps
`default_nettype none

module dda_line_rasterizer
  import dda_pkg::*;
#(
  parameter int COORD_BITS = 6,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // start_x, start_y, end_x, end_y
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // pixel_x, pixel_y, zero fill
  output logic                        out_tlast   // last_pixel
);

  localparam int INC_W = FRAC_BITS + 2;
  localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;

  dda_state_t state_r, state_nxt;

  logic [COORD_BITS-1:0] sx, sy, ex, ey, adx, ady, steps, minor;
  logic                  in_fire, x_major;
  logic [COORD_BITS-1:0] cnt_r, cnt_nxt;
  logic                  neg_x_r, neg_x_nxt, neg_y_r, neg_y_nxt;
  logic                  xmaj_r, xmaj_nxt;
  logic signed [INC_W-1:0] inc_x_r, inc_x_nxt, inc_y_r, inc_y_nxt;
  logic [FRAC_BITS:0]    mag_x, mag_y;
  logic                  div_done;
  logic [FRAC_BITS:0]    div_q;
  acc_ctrl_t             acc_ctrl;
  logic [COORD_BITS-1:0] pix_x, pix_y;
  logic                  emit;
  logic                  out_valid_r, out_valid_nxt;
  logic [FIELD_W-1:0]    out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  logic                  out_last_r, out_last_nxt;

  // unpack and measure the line
  always_comb begin
    sx      = in_tdata[COORD_BITS-1:0];
    sy      = in_tdata[FIELD_W +: COORD_BITS];
    ex      = in_tdata[2*FIELD_W +: COORD_BITS];
    ey      = in_tdata[3*FIELD_W +: COORD_BITS];
    adx     = (ex >= sx) ? (ex - sx) : (sx - ex);
    ady     = (ey >= sy) ? (ey - sy) : (sy - ey);
    x_major = adx >= ady;
    steps   = x_major ? adx : ady;
    minor   = x_major ? ady : adx;
  end

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign emit      = (state_r == ST_EMIT) && (!out_valid_r || out_tready);

  // shared increment divider
  dda_div #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (in_fire && (steps != '0)),
    .dividend(minor),
    .divisor (steps),
    .done    (div_done),
    .quotient(div_q)
  );

  // major axis steps by one pixel, minor by the quotient
  always_comb begin
    mag_x = xmaj_r ? ONE : div_q;
    mag_y = xmaj_r ? div_q : ONE;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    neg_x_nxt = neg_x_r;
    neg_y_nxt = neg_y_r;
    xmaj_nxt  = xmaj_r;
    inc_x_nxt = inc_x_r;
    inc_y_nxt = inc_y_r;
    acc_ctrl  = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          acc_ctrl.load = 1'b1;
          cnt_nxt       = steps;
          neg_x_nxt     = ex < sx;
          neg_y_nxt     = ey < sy;
          xmaj_nxt      = x_major;
          state_nxt     = (steps == '0) ? ST_EMIT : ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          inc_x_nxt = neg_x_r ? -$signed({1'b0, mag_x}) : $signed({1'b0, mag_x});
          inc_y_nxt = neg_y_r ? -$signed({1'b0, mag_y}) : $signed({1'b0, mag_y});
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit) begin
          if (cnt_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            acc_ctrl.step = 1'b1;
            cnt_nxt       = cnt_r - 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // pixel accumulators
  dda_acc #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_acc (
    .clk    (clk),
    .ctrl   (acc_ctrl),
    .start_x(sx),
    .start_y(sy),
    .inc_x  (inc_x_r),
    .inc_y  (inc_y_r),
    .pix_x  (pix_x),
    .pix_y  (pix_y)
  );

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_x_nxt     = FIELD_W'(pix_x);
      out_y_nxt     = FIELD_W'(pix_y);
      out_last_nxt  = (cnt_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // line parameters and output payload
  always_ff @(posedge clk) begin
    neg_x_r    <= neg_x_nxt;
    neg_y_r    <= neg_y_nxt;
    xmaj_r     <= xmaj_nxt;
    inc_x_r    <= inc_x_nxt;
    inc_y_r    <= inc_y_nxt;
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - 2*FIELD_W){1'b0}}, out_y_r, out_x_r};
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

// ----- rtl/dda_div.sv -----
// restoring divider, one quotient bit per cycle, for the minor-axis increment
// computes (dividend << FRAC_BITS) / divisor with dividend <= divisor; uses dda_pkg
`timescale 1ns / 1ps
`default_nettype none

module dda_div
  import dda_pkg::*;
#(
  parameter int COORD_BITS = 6,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [COORD_BITS-1:0] dividend,
  input  wire logic [COORD_BITS-1:0] divisor,
  output logic                       done,
  output logic [FRAC_BITS:0]         quotient
);

  localparam int CNT_W = $clog2(FRAC_BITS + 2);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(FRAC_BITS);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [COORD_BITS:0]   rem_r, rem_nxt;
  logic [COORD_BITS-1:0] dvs_r, dvs_nxt;
  logic [FRAC_BITS:0]    quo_r, quo_nxt;
  logic                  ge;
  logic [COORD_BITS:0]   diff;

  // one compare and subtract per cycle
  always_comb begin
    ge   = rem_r >= {1'b0, dvs_r};
    diff = ge ? (rem_r - {1'b0, dvs_r}) : rem_r;
  end

  // iteration control
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = {1'b0, dividend};
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[FRAC_BITS-1:0], ge};
      rem_nxt = {diff[COORD_BITS-1:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST_CNT) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// ----- rtl/dda_acc.sv -----
// x and y fixed-point accumulators with round-half-up and range clamp
// controlled by acc_ctrl_t from dda_pkg
`timescale 1ns / 1ps
`default_nettype none

module dda_acc
  import dda_pkg::*;
#(
  parameter int COORD_BITS = 6,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                        clk,
  input  wire acc_ctrl_t                   ctrl,
  input  wire logic [COORD_BITS-1:0]       start_x,
  input  wire logic [COORD_BITS-1:0]       start_y,
  input  wire logic signed [FRAC_BITS+1:0] inc_x,
  input  wire logic signed [FRAC_BITS+1:0] inc_y,
  output logic [COORD_BITS-1:0]            pix_x,
  output logic [COORD_BITS-1:0]            pix_y
);

  localparam int INC_W = FRAC_BITS + 2;
  localparam int ACC_W = COORD_BITS + FRAC_BITS + 2;
  localparam int RND_W = ACC_W + 1;
  localparam int INT_W = RND_W - FRAC_BITS;
  localparam logic signed [RND_W-1:0] HALF = RND_W'(1) <<< (FRAC_BITS - 1);
  localparam logic [INT_W-1:0] MAX_PIX = INT_W'((1 << COORD_BITS) - 1);

  logic signed [ACC_W-1:0] acc_x_r, acc_x_nxt;
  logic signed [ACC_W-1:0] acc_y_r, acc_y_nxt;

  // floor(acc + 0.5), clamped to the coordinate range
  function automatic logic [COORD_BITS-1:0] round_pix(input logic signed [ACC_W-1:0] acc);
    logic signed [RND_W-1:0] v;
    logic [INT_W-1:0]        p;
    v = RND_W'(acc) + HALF;
    p = v[RND_W-1:FRAC_BITS];
    if (v[RND_W-1]) begin
      round_pix = '0;
    end else if (p > MAX_PIX) begin
      round_pix = MAX_PIX[COORD_BITS-1:0];
    end else begin
      round_pix = p[COORD_BITS-1:0];
    end
  endfunction

  // load or step
  always_comb begin
    acc_x_nxt = acc_x_r;
    acc_y_nxt = acc_y_r;
    if (ctrl.load) begin
      acc_x_nxt = {2'b00, start_x, {FRAC_BITS{1'b0}}};
      acc_y_nxt = {2'b00, start_y, {FRAC_BITS{1'b0}}};
    end else if (ctrl.step) begin
      acc_x_nxt = acc_x_r + {{(ACC_W-INC_W){inc_x[INC_W-1]}}, inc_x};
      acc_y_nxt = acc_y_r + {{(ACC_W-INC_W){inc_y[INC_W-1]}}, inc_y};
    end
  end

  always_ff @(posedge clk) begin
    acc_x_r <= acc_x_nxt;
    acc_y_r <= acc_y_nxt;
  end

  assign pix_x = round_pix(acc_x_r);
  assign pix_y = round_pix(acc_y_r);

endmodule

`default_nettype wire

// ----- dv/dda_line_rasterizer_test.sv -----
// self-checking testbench for dda_line_rasterizer: streams lines in, predicts
// every pixel of each line and checks the pixel stream. depends on dda_pkg and the rtl
`timescale 1ns / 1ps

module dda_line_rasterizer_test;
  import dda_pkg::*;

  localparam int COORD_BITS  = 6;
  localparam int FRAC_BITS   = 16;
  localparam int ACC_W       = 23;
  localparam int INC_W       = FRAC_BITS + 2;
  localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_LIMIT = 4000;
  localparam int TAIL_CYCLES = FRAC_BITS + 4 + 64 + 16;
  localparam int RANDOM_LINES = 200;
  localparam int TAIL_LINES   = 25;

  typedef struct packed {
    logic [FIELD_W-1:0] x;
    logic [FIELD_W-1:0] y;
    logic               last;
  } pixel_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // start_x, start_y, end_x, end_y
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // pixel_x, pixel_y, zero fill
  logic                   out_tlast;  // last_pixel

  pixel_t expected_pixels[$];
  int     mismatch_count;
  bit     idle_en;
  bit     hold_request;

  dda_line_rasterizer #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // per-axis step: d / steps in signed fixed point, truncated toward zero
  function automatic logic signed [INC_W-1:0] axis_step(int d, int steps);
    int mag;
    int q;
    if (steps == 0) return '0;
    mag = (d < 0) ? -d : d;
    q = (mag << FRAC_BITS) / steps;
    return (d < 0) ? INC_W'(-q) : INC_W'(q);
  endfunction

  // floor(acc + 0.5), saturated to the coordinate range
  function automatic logic [FIELD_W-1:0] round_coord(logic signed [ACC_W-1:0] acc);
    longint biased;
    biased = acc + (longint'(1) << (FRAC_BITS - 1));
    if (biased < 0) return '0;
    if ((biased >>> FRAC_BITS) > COORD_MAX) return FIELD_W'(COORD_MAX);
    return FIELD_W'(biased >>> FRAC_BITS);
  endfunction

  // queue every pixel that one line transfer should produce
  function automatic void predict_line_pixels(logic [IN_TDATA_W-1:0] word);
    logic [FIELD_W-1:0]      sx, sy, ex, ey;
    int                      dx, dy, adx, ady, steps;
    logic signed [INC_W-1:0] inc_x, inc_y;
    logic signed [ACC_W-1:0] acc_x, acc_y;
    pixel_t                  px;
    sx = word[0 +: FIELD_W];
    sy = word[FIELD_W +: FIELD_W];
    ex = word[2*FIELD_W +: FIELD_W];
    ey = word[3*FIELD_W +: FIELD_W];
    dx = int'(ex) - int'(sx);
    dy = int'(ey) - int'(sy);
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    steps = (adx > ady) ? adx : ady;
    inc_x = axis_step(dx, steps);
    inc_y = axis_step(dy, steps);
    acc_x = '0;
    acc_y = '0;
    acc_x[FRAC_BITS +: FIELD_W] = sx;
    acc_y[FRAC_BITS +: FIELD_W] = sy;
    // start pixel, alone on the line when the endpoints match
    px.x = sx;
    px.y = sy;
    px.last = (steps == 0);
    expected_pixels.push_back(px);
    for (int n = 1; n <= steps; n++) begin
      acc_x += inc_x;
      acc_y += inc_y;
      px.x = round_coord(acc_x);
      px.y = round_coord(acc_y);
      px.last = (n == steps);
      expected_pixels.push_back(px);
    end
  endfunction

  function automatic void report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch at %0t: %s", $realtime, msg);
  endfunction

  // monitor: predict on each line transfer, check each pixel transfer
  always @(posedge clk) begin : monitor
    pixel_t got;
    pixel_t want;
    if (rst_n && in_tvalid && in_tready) predict_line_pixels(in_tdata);
    if (rst_n && out_tvalid && out_tready) begin
      got.x = out_tdata[0 +: FIELD_W];
      got.y = out_tdata[FIELD_W +: FIELD_W];
      got.last = out_tlast;
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("pixel with no line pending: x=%0d y=%0d last=%0d",
                                  got.x, got.y, got.last));
      end else begin
        want = expected_pixels.pop_front();
        if (got.x !== want.x)
          report_mismatch($sformatf("pixel_x expected %0d got %0d", want.x, got.x));
        if (got.y !== want.y)
          report_mismatch($sformatf("pixel_y expected %0d got %0d", want.y, got.y));
        if (got.last !== want.last)
          report_mismatch($sformatf("last_pixel expected %0d got %0d", want.last, got.last));
      end
    end
  end

  // receiver: random stall bursts, plus a long hold when requested
  initial begin : receiver
    int hold_left;
    int stall_left;
    hold_left = 0;
    stall_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 13) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog: too many cycles without any transfer ends the run
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("status: fail");
    $finish;
  end

  // offer one line, optionally after an idle burst, and wait for the transfer
  task automatic send_line(input logic [FIELD_W-1:0] sx, sy, ex, ey);
    int gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {ey, ex, sy, sx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // random line: mostly arbitrary, some short, flat, steep or degenerate
  task automatic send_random_line();
    logic [FIELD_W-1:0] sx, sy, ex, ey;
    int kind;
    sx = $urandom_range(0, COORD_MAX);
    sy = $urandom_range(0, COORD_MAX);
    ex = $urandom_range(0, COORD_MAX);
    ey = $urandom_range(0, COORD_MAX);
    kind = $urandom_range(0, 9);
    if (kind inside {6, 7}) begin
      ex = sx ^ FIELD_W'($urandom_range(0, 7));
      ey = sy ^ FIELD_W'($urandom_range(0, 7));
    end else if (kind == 8) begin
      ex = sx;
      ey = sy;
    end else if (kind == 9) begin
      if ($urandom_range(0, 1)) ey = sy;
      else ex = sx;
    end
    send_line(sx, sy, ex, ey);
  endtask

  // corners, full-span diagonals, axis lines and one full-width sloped line
  task automatic test_extremes();
    send_line(6'd0, 6'd0, 6'd63, 6'd63);
    send_line(6'd63, 6'd63, 6'd0, 6'd0);
    send_line(6'd0, 6'd63, 6'd63, 6'd0);
    send_line(6'd63, 6'd0, 6'd0, 6'd63);
    send_line(6'd0, 6'd0, 6'd63, 6'd0);
    send_line(6'd0, 6'd0, 6'd0, 6'd63);
    send_line(6'd63, 6'd21, 6'd0, 6'd42);
  endtask

  // equal endpoints give a single pixel with no division
  task automatic test_equal_endpoints();
    send_line(6'd0, 6'd0, 6'd0, 6'd0);
    send_line(6'd63, 6'd63, 6'd63, 6'd63);
    send_line(6'd21, 6'd42, 6'd21, 6'd42);
  endtask

  // all eight octants, one-step lines and half-pixel rounding
  task automatic test_octants();
    send_line(6'd32, 6'd32, 6'd40, 6'd35);
    send_line(6'd32, 6'd32, 6'd35, 6'd40);
    send_line(6'd32, 6'd32, 6'd29, 6'd40);
    send_line(6'd32, 6'd32, 6'd24, 6'd35);
    send_line(6'd32, 6'd32, 6'd24, 6'd29);
    send_line(6'd32, 6'd32, 6'd29, 6'd24);
    send_line(6'd32, 6'd32, 6'd35, 6'd24);
    send_line(6'd32, 6'd32, 6'd40, 6'd29);
    send_line(6'd10, 6'd10, 6'd11, 6'd10);
    send_line(6'd10, 6'd10, 6'd10, 6'd9);
    send_line(6'd0, 6'd0, 6'd2, 6'd1);
    send_line(6'd5, 6'd5, 6'd1, 6'd2);
    send_line(6'd0, 6'd0, 6'd63, 6'd1);
  endtask

  task automatic test_random_lines();
    repeat (RANDOM_LINES) send_random_line();
  endtask

  // receiver holds off while lines keep being offered
  task automatic test_backpressure();
    hold_request = 1'b1;
    repeat (8) send_random_line();
  endtask

  // back-to-back lines with no idling on either side
  task automatic test_streaming_tail();
    idle_en = 1'b0;
    repeat (TAIL_LINES) send_random_line();
  endtask

  task automatic wait_drain();
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  initial begin
    mismatch_count = 0;
    idle_en = 1'b1;
    hold_request = 1'b0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes();
    test_equal_endpoints();
    test_octants();
    test_random_lines();
    test_backpressure();
    test_streaming_tail();

    in_tvalid <= 1'b0;
    wait_drain();
    if (expected_pixels.size() != 0) report_mismatch("pixels left undelivered");

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/dda_pkg.sv
rtl/dda_div.sv
rtl/dda_acc.sv
rtl/dda_line_rasterizer.sv
dv/dda_line_rasterizer_test.sv
